/* design/rid_pkg.sv */
// rid_pkg: shared types and codes for the remapped input debouncer.
// Holds the payload structs of both channels, the per-channel control bundle
// and the action and register index codes. No dependencies.
package rid_pkg;

	localparam int OUT_W = 50;   // width of the result words
	localparam int PIN_W = 64;   // width of the raw pin word
	localparam int IDX_W = 6;    // width of channel and pin numbers
	localparam int CNT_W = 8;    // counter and threshold width

	localparam logic ACT_SCAN = 1'b0;
	localparam logic ACT_MAP  = 1'b1;

	localparam logic [1:0] REG_RISE = 2'd0;
	localparam logic [1:0] REG_FALL = 2'd1;

	localparam logic [CNT_W-1:0] RISE_RESET = 8'd8;
	localparam logic [CNT_W-1:0] FALL_RESET = 8'd0;
	localparam logic [CNT_W-1:0] CNT_MAX    = 8'd255;

	typedef struct packed {
		logic             action;
		logic [PIN_W-1:0] raw_pins;
		logic [IDX_W-1:0] map_channel;
		logic [IDX_W-1:0] map_pin;
	} item_t;

	typedef struct packed {
		logic [OUT_W-1:0] filtered_inputs;
		logic [OUT_W-1:0] previous_inputs;
	} result_t;

	// Control shared by every channel slice for one word.
	typedef struct packed {
		logic             scan;
		logic [IDX_W-1:0] map_pin;
		logic [CNT_W-1:0] rise;
		logic [CNT_W-1:0] fall;
	} chan_ctl_t;

endpackage

/* design/rid_chan.sv */
// rid_chan: one logical channel: pin map entry, integrating counter and the
// filtered and previous level bits. Depends on rid_pkg.
module rid_chan #(
	parameter int CH_INDEX = 0,
	parameter int RAW_PINS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rid_pkg::chan_ctl_t        ctl,
	input  logic                      map_wr,
	input  logic [rid_pkg::PIN_W-1:0] raw_pins,
	output logic                      filt,
	output logic                      prev
);

	localparam logic [rid_pkg::IDX_W-1:0] MAP_RESET = rid_pkg::IDX_W'(CH_INDEX % 64);
	localparam logic [rid_pkg::IDX_W:0]   PIN_LIMIT = (rid_pkg::IDX_W+1)'(RAW_PINS);

	logic [rid_pkg::IDX_W-1:0] pin_q;
	logic [rid_pkg::CNT_W-1:0] cnt_q;
	logic                      filt_q;
	logic                      prev_q;

	logic                      level;
	logic [rid_pkg::CNT_W-1:0] cnt_up;
	logic [rid_pkg::CNT_W-1:0] cnt_dn;
	logic [rid_pkg::CNT_W-1:0] cnt_d;
	logic                      refresh;

	always_comb begin
		level   = ({1'b0, pin_q} < PIN_LIMIT) && raw_pins[pin_q];
		cnt_up  = (cnt_q == rid_pkg::CNT_MAX) ? cnt_q : cnt_q + rid_pkg::CNT_W'(1);
		cnt_dn  = (cnt_q == '0) ? cnt_q : cnt_q - rid_pkg::CNT_W'(1);
		refresh = 1'b0;
		if (level) begin
			cnt_d = cnt_up;
			if (cnt_up >= ctl.rise) begin
				cnt_d   = ctl.rise;
				refresh = 1'b1;
			end
		end else begin
			cnt_d = cnt_dn;
			if (cnt_dn <= ctl.fall) begin
				cnt_d   = '0;
				refresh = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q  <= MAP_RESET;
			cnt_q  <= '0;
			filt_q <= 1'b0;
			prev_q <= 1'b0;
		end else begin
			if (map_wr) begin
				pin_q <= ctl.map_pin;
			end
			if (ctl.scan) begin
				cnt_q <= cnt_d;
				// refresh: keep the old level, then take the sampled one
				if (refresh) begin
					prev_q <= filt_q;
					filt_q <= level;
				end
			end
		end
	end

	assign filt = filt_q;
	assign prev = prev_q;

endmodule

/* design/remapped_input_debouncer_top.sv */
// remapped_input_debouncer_top: input word register, channel slices and the
// result handshake. Depends on rid_pkg and rid_chan.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   item     | item_valid, item_ready, item         | in
//   result   | result_valid, result_ready, result   | out
//   cfg      | cfg_valid, cfg_ready, cfg_index/data | in
//
// One word per cycle while no result is stalled.
// The per-channel counter and level registers double as the result register,
// so the input register holds while a result is stalled.
// Reset restores the pin map (channel i on pin i), clears counters and levels
// and loads the default thresholds; no clearing pass is needed.
module remapped_input_debouncer_top #(
	parameter int CHANNELS = 50,
	parameter int RAW_PINS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  rid_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output rid_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data
);

	localparam int PAD_W = (CHANNELS > rid_pkg::OUT_W) ? CHANNELS : rid_pkg::OUT_W;

	logic                      valid_s1;
	rid_pkg::item_t            item_s1;
	logic                      result_valid_q;
	logic [rid_pkg::CNT_W-1:0] rise_q;
	logic [rid_pkg::CNT_W-1:0] fall_q;

	logic                      adv;
	rid_pkg::chan_ctl_t        ctl;
	logic [CHANNELS-1:0]       filt_word;
	logic [CHANNELS-1:0]       prev_word;
	logic [PAD_W-1:0]          filt_pad;
	logic [PAD_W-1:0]          prev_pad;

	// advance the input word once the result slot is free
	assign adv        = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			rise_q         <= rid_pkg::RISE_RESET;
			fall_q         <= rid_pkg::FALL_RESET;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (adv) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					rid_pkg::REG_RISE: rise_q <= cfg_data;
					rid_pkg::REG_FALL: fall_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		ctl.scan    = adv && (item_s1.action == rid_pkg::ACT_SCAN);
		ctl.map_pin = item_s1.map_pin;
		ctl.rise    = rise_q;
		ctl.fall    = fall_q;
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
		logic map_wr;

		assign map_wr = adv && (item_s1.action == rid_pkg::ACT_MAP)
			&& (item_s1.map_channel == rid_pkg::IDX_W'(i));

		rid_chan #(
			.CH_INDEX (i),
			.RAW_PINS (RAW_PINS)
		) u_chan (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.map_wr   (map_wr),
			.raw_pins (item_s1.raw_pins),
			.filt     (filt_word[i]),
			.prev     (prev_word[i])
		);
	end

	assign filt_pad = PAD_W'(filt_word);
	assign prev_pad = PAD_W'(prev_word);

	assign result_valid           = result_valid_q;
	assign result.filtered_inputs = filt_pad[rid_pkg::OUT_W-1:0];
	assign result.previous_inputs = prev_pad[rid_pkg::OUT_W-1:0];

endmodule
